>>> sv/bba_pkg.sv
package bba_pkg;

   // default sizes
   localparam int NUM_POOLS_DEF  = 8;
   localparam int MIN_ORDER_DEF  = 4;
   localparam int POOL_ORDER_DEF = 14;

   // fixed widths from the field definitions
   localparam int SUM_W  = 16;
   localparam int CLOG_W = 5;
   localparam int HDR_W  = 9;
   localparam int CSR_AW = 3;

   typedef struct packed {
      logic        command;
      logic [2:0]  pool;
      logic [13:0] request_size;
      logic [13:0] block_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] granted_address;
      logic [13:0] user_address;
      logic [3:0]  granted_order;
   } rsp_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NO_BLOCK  = 2'd1;
   localparam logic [1:0] STS_NOT_ALLOC = 2'd2;

   localparam logic [1:0] NODE_ABSENT = 2'd0;
   localparam logic [1:0] NODE_FREE   = 2'd1;
   localparam logic [1:0] NODE_ALLOC  = 2'd2;
   localparam logic [1:0] NODE_SPLIT  = 2'd3;

   localparam logic [7:0] HDR_RESET      = 8'd40;
   localparam logic       CSR_IDX_HEADER = 1'b0;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_SIZE,
      ST_A_SUM,
      ST_A_ORD,
      ST_SCAN,
      ST_SPLIT_A,
      ST_SPLIT_B,
      ST_A_ADDR,
      ST_A_DONE,
      ST_F_RD,
      ST_F_CHK,
      ST_M_RD,
      ST_M_CHK,
      ST_M_CLR,
      ST_M_FIN,
      ST_FAIL
   } state_type;

   // smallest o with 2^o >= v, zero for v of zero or one
   function automatic logic [CLOG_W-1:0] ceil_log2(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0]  w;
      logic [CLOG_W-1:0] r;
      w = v - 1'b1;
      r = '0;
      if (v > SUM_W'(1)) begin
         for (int i = 0; i < SUM_W; i++) begin
            if (w[i]) r = CLOG_W'(i + 1);
         end
      end
      return r;
   endfunction

endpackage

>>> sv/buddy_block_allocator_unit.sv
// allocate: sizes the request, scans nodes from the target level up to the root, then splits
//   down to the target level; a miss fails once every level up to the root is scanned
// free: walks down the tree level by level, merges with free buddies, then marks the block free
// throughput: one request at a time, the next one is taken in the result beat cycle; the
//   node scan sets the time, one node access per cycle; the receiver cannot stall
// reset: synchronous; a clearing pass over every node store entry keeps busy high
module buddy_block_allocator_unit #(
   parameter int NUM_POOLS  = bba_pkg::NUM_POOLS_DEF,
   parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF,
   parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  bba_pkg::req_type           req_data,
   // result channel
   output logic                       rsp_valid,
   output bba_pkg::rsp_type           rsp_data,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bba_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import bba_pkg::*;

   // tree geometry
   localparam int LEVELS = POOL_ORDER - MIN_ORDER;
   localparam int NW     = LEVELS + 1;                       // node index bits
   localparam int PIW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int AW     = PIW + NW;                         // node store address bits
   localparam int DEPTH  = 1 << AW;
   localparam int XW     = POOL_ORDER + 1;                   // byte offset math
   localparam int OW     = $clog2(POOL_ORDER + 1);
   localparam int LW     = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

   state_type state_ff, state_in;

   logic [7:0]        hdr_ff, hdr_in;
   req_type           req_ff, req_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [HDR_W-1:0]  hdr_rnd_ff, hdr_rnd_in;
   logic [CLOG_W-1:0] uo_ff, uo_in;
   logic              unz_ff, unz_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [LW-1:0]     tgt_lvl_ff, tgt_lvl_in;
   logic [NW-1:0]     scan_node_ff, scan_node_in;
   logic [LW-1:0]     scan_lvl_ff, scan_lvl_in;
   logic              scan_done_ff, scan_done_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [NW-1:0]     pend_node_ff, pend_node_in;
   logic [LW-1:0]     pend_lvl_ff, pend_lvl_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [XW-1:0]     addr_ff, addr_in;
   logic [1:0]        fail_ff, fail_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // node store: one port written, one read, read data registered
   logic [1:0]    node_mem [DEPTH];
   logic [1:0]    rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [1:0]    mem_wd;

   // helpers
   logic [31:0]       pool_ext;
   logic [PIW-1:0]    pool_sel;
   logic              accept;
   logic              csr_wr;
   logic [OW-1:0]     cur_order;
   logic [XW-1:0]     free_addr;
   logic [CLOG_W-1:0] need_order;
   logic [NW:0]       level_end;

   assign accept    = start && (state_ff == ST_IDLE);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign pool_ext  = 32'(req_ff.pool);
   assign pool_sel  = pool_ext[PIW-1:0];
   assign cur_order = OW'(POOL_ORDER) - OW'(lvl_ff);
   assign free_addr = XW'(req_ff.block_address);
   // last node of the scanned level plus one
   assign level_end = (NW + 1)'(1) << (scan_lvl_ff + 1'b1);

   always_comb begin
      logic [CLOG_W-1:0] r;
      r = ceil_log2(sum_ff);
      need_order = (r < CLOG_W'(MIN_ORDER)) ? CLOG_W'(MIN_ORDER) : r;
   end

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, hdr_ff};
   always_comb begin
      hdr_in = hdr_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_HEADER)) hdr_in = csr_pwdata[7:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.command == CMD_ALLOC) begin
                  state_in = ST_A_SIZE;
               end else if ((32'(req_data.pool) < 32'(NUM_POOLS)) &&
                            ({18'd0, req_data.block_address} < (32'd1 << POOL_ORDER))) begin
                  state_in = ST_F_RD;
               end else begin
                  state_in = ST_FAIL;
               end
            end
         end
         ST_A_SIZE: state_in = ST_A_SUM;
         ST_A_SUM:  state_in = ST_A_ORD;
         ST_A_ORD: begin
            if ((pool_ext >= 32'(NUM_POOLS)) ||
                ({1'b0, need_order} > (CLOG_W + 1)'(POOL_ORDER))) state_in = ST_FAIL;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            priority if (pend_valid_ff && (rdata_ff == NODE_FREE)) state_in = ST_SPLIT_A;
            else if (scan_done_ff && !pend_valid_ff) state_in = ST_FAIL;
            else state_in = ST_SCAN;
         end
         ST_SPLIT_A: begin
            if (lvl_ff == tgt_lvl_ff) state_in = ST_A_ADDR;
            else state_in = ST_SPLIT_B;
         end
         ST_SPLIT_B: state_in = ST_SPLIT_A;
         ST_A_ADDR:  state_in = ST_A_DONE;
         ST_A_DONE:  state_in = ST_IDLE;
         ST_F_RD:    state_in = ST_F_CHK;
         ST_F_CHK: begin
            priority if (rdata_ff == NODE_ALLOC) begin
               if ((free_addr & ((XW'(1) << cur_order) - 1'b1)) != '0) state_in = ST_FAIL;
               else state_in = ST_M_RD;
            end else if ((rdata_ff == NODE_SPLIT) && (32'(lvl_ff) < 32'(LEVELS))) begin
               state_in = ST_F_RD;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_M_RD: begin
            if (idx_ff == NW'(1)) state_in = ST_M_FIN;
            else state_in = ST_M_CHK;
         end
         ST_M_CHK: begin
            if (rdata_ff == NODE_FREE) state_in = ST_M_CLR;
            else state_in = ST_M_FIN;
         end
         ST_M_CLR: state_in = ST_M_RD;
         ST_M_FIN: state_in = ST_IDLE;
         ST_FAIL:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [SUM_W-1:0] user;
      logic [XW-1:0]    ua;
      logic [XW-1:0]    um1;
      logic [OW-1:0]    nord;
      logic [XW-1:0]    shifted;

      req_in        = req_ff;
      clr_in        = clr_ff;
      hdr_rnd_in    = hdr_rnd_ff;
      uo_in         = uo_ff;
      unz_in        = unz_ff;
      sum_in        = sum_ff;
      tgt_lvl_in    = tgt_lvl_ff;
      scan_node_in  = scan_node_ff;
      scan_lvl_in   = scan_lvl_ff;
      scan_done_in  = scan_done_ff;
      pend_valid_in = 1'b0;
      pend_node_in  = pend_node_ff;
      pend_lvl_in   = pend_lvl_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      addr_in       = addr_ff;
      fail_in       = fail_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = {pool_sel, idx_ff};
      mem_wd        = NODE_ABSENT;
      mem_ra        = {pool_sel, idx_ff};
      user          = '0;
      ua            = '0;
      um1           = '0;
      nord          = '0;
      shifted       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // top node free, everything else absent
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_ff[NW-1:0] == NW'(1)) ? NODE_FREE : NODE_ABSENT;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               idx_in  = NW'(1);
               lvl_in  = '0;
               fail_in = (req_data.command == CMD_ALLOC) ? STS_NO_BLOCK : STS_NOT_ALLOC;
            end
         end
         ST_A_SIZE: begin
            uo_in      = ceil_log2(SUM_W'(req_ff.request_size));
            unz_in     = (req_ff.request_size != '0);
            hdr_rnd_in = (HDR_W'(hdr_ff) + HDR_W'(7)) & ~HDR_W'(7);
         end
         ST_A_SUM: begin
            user   = unz_ff ? (SUM_W'(1) << uo_ff) : '0;
            sum_in = user + SUM_W'(hdr_rnd_ff);
         end
         ST_A_ORD: begin
            tgt_lvl_in   = LW'(POOL_ORDER - int'(need_order));
            scan_lvl_in  = LW'(POOL_ORDER - int'(need_order));
            scan_node_in = NW'(1) << LW'(POOL_ORDER - int'(need_order));
            scan_done_in = 1'b0;
         end
         ST_SCAN: begin
            // one node read per cycle, checked in the next cycle
            mem_ra = {pool_sel, scan_node_ff};
            if (pend_valid_ff && (rdata_ff == NODE_FREE)) begin
               idx_in = pend_node_ff;
               lvl_in = pend_lvl_ff;
            end else if (!scan_done_ff) begin
               pend_valid_in = 1'b1;
               pend_node_in  = scan_node_ff;
               pend_lvl_in   = scan_lvl_ff;
               if ((NW + 1)'(scan_node_ff) + 1'b1 == level_end) begin
                  if (scan_lvl_ff == '0) begin
                     scan_done_in = 1'b1;
                  end else begin
                     scan_lvl_in  = scan_lvl_ff - 1'b1;
                     scan_node_in = NW'(1) << (scan_lvl_ff - 1'b1);
                  end
               end else begin
                  scan_node_in = scan_node_ff + 1'b1;
               end
            end
         end
         ST_SPLIT_A: begin
            mem_we = 1'b1;
            mem_wd = (lvl_ff == tgt_lvl_ff) ? NODE_ALLOC : NODE_SPLIT;
         end
         ST_SPLIT_B: begin
            // upper half freed, descend into the lower one
            mem_we = 1'b1;
            mem_wa = {pool_sel, (idx_ff << 1) | NW'(1)};
            mem_wd = NODE_FREE;
            idx_in = idx_ff << 1;
            lvl_in = lvl_ff + 1'b1;
         end
         ST_A_ADDR: begin
            addr_in = XW'(idx_ff - (NW'(1) << lvl_ff)) << cur_order;
         end
         ST_A_DONE: begin
            ua = addr_ff + XW'(hdr_rnd_ff);
            if (unz_ff) begin
               um1 = (XW'(1) << uo_ff) - 1'b1;
               ua  = (ua + um1) & ~um1;
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status: STS_OK, granted_address: 14'(addr_ff),
                             user_address: 14'(ua), granted_order: 4'(cur_order)};
         end
         ST_F_RD: begin
            mem_ra = {pool_sel, idx_ff};
         end
         ST_F_CHK: begin
            if ((rdata_ff == NODE_SPLIT) && (32'(lvl_ff) < 32'(LEVELS))) begin
               nord    = cur_order - 1'b1;
               shifted = free_addr >> nord;
               idx_in  = (idx_ff << 1) | NW'(shifted[0]);
               lvl_in  = lvl_ff + 1'b1;
            end
         end
         ST_M_RD: begin
            mem_ra = {pool_sel, idx_ff ^ NW'(1)};
         end
         ST_M_CHK: begin
            if (rdata_ff == NODE_FREE) begin
               mem_we = 1'b1;
               mem_wa = {pool_sel, idx_ff ^ NW'(1)};
               mem_wd = NODE_ABSENT;
            end
         end
         ST_M_CLR: begin
            mem_we = 1'b1;
            mem_wd = NODE_ABSENT;
            idx_in = idx_ff >> 1;
            lvl_in = lvl_ff - 1'b1;
         end
         ST_M_FIN: begin
            mem_we       = 1'b1;
            mem_wd       = NODE_FREE;
            shifted      = XW'(idx_ff - (NW'(1) << lvl_ff)) << cur_order;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status: STS_OK, granted_address: 14'(shifted),
                             user_address: 14'd0, granted_order: 4'(cur_order)};
         end
         ST_FAIL: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status: fail_ff, granted_address: 14'd0,
                             user_address: 14'd0, granted_order: 4'd0};
         end
         default: begin
         end
      endcase
   end

   // node store
   always_ff @(posedge clock) begin
      if (mem_we) node_mem[mem_wa] <= mem_wd;
      rdata_ff <= node_mem[mem_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         hdr_ff        <= HDR_RESET;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         hdr_ff        <= hdr_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      hdr_rnd_ff   <= hdr_rnd_in;
      uo_ff        <= uo_in;
      unz_ff       <= unz_in;
      sum_ff       <= sum_in;
      tgt_lvl_ff   <= tgt_lvl_in;
      scan_node_ff <= scan_node_in;
      scan_lvl_ff  <= scan_lvl_in;
      scan_done_ff <= scan_done_in;
      pend_node_ff <= pend_node_in;
      pend_lvl_ff  <= pend_lvl_in;
      idx_ff       <= idx_in;
      lvl_ff       <= lvl_in;
      addr_ff      <= addr_in;
      fail_ff      <= fail_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a result beat always leaves the sequencer back in idle
   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result beat while sequencer active");

   // an accepted request never yields a beat in the very next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid_ff)
      else $error("result beat right after accept");

   // failed requests carry zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != STS_OK)) |->
      ((rsp_data_ff.granted_address == 14'd0) && (rsp_data_ff.user_address == 14'd0) &&
       (rsp_data_ff.granted_order == 4'd0)))
      else $error("failed result with nonzero fields");

   // the clearing pass ends only into idle
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) && (clr_ff == '1)) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not end in idle");
`endif

endmodule

>>> verif/bba_checker.sv
module bba_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  bba_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  bba_pkg::rsp_type             rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic                         csr_pready,
   input  logic [bba_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output int                           fail_count,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bba_pkg::*;

   localparam int POOLS = NUM_POOLS_DEF;
   localparam int MINO  = MIN_ORDER_DEF;
   localparam int TOPO  = POOL_ORDER_DEF;
   localparam int NODES = 1 << (TOPO - MINO + 1);

   logic [1:0] tree [POOLS][NODES];
   logic [7:0] header_reg;
   rsp_type    expected_rsps [$];

   function automatic int log2_up(longint v);
      int     o;
      longint s;
      o = 0;
      s = 1;
      while (s < v) begin
         s = s << 1;
         o++;
      end
      return o;
   endfunction

   function automatic rsp_type alloc_block(int p, int size);
      rsp_type r;
      int      hdr, user, need, o, i, idx, found_o, lvl, first;
      longint  addr, ua;
      r = '0;
      hdr = (int'(header_reg) + 7) & ~7;
      user = (size > 0) ? (1 << log2_up(size)) : 0;
      need = log2_up(user + hdr);
      if (need < MINO) need = MINO;
      if (p >= POOLS || need > TOPO) begin
         r.status = STS_NO_BLOCK;
         return r;
      end
      idx = 0;
      found_o = 0;
      // lowest-address free block of the smallest order that fits
      for (o = need; o <= TOPO && idx == 0; o++) begin
         first = 1 << (TOPO - o);
         for (i = first; i < 2 * first && idx == 0; i++) begin
            if (tree[p][i] == NODE_FREE) begin
               idx = i;
               found_o = o;
            end
         end
      end
      if (idx == 0) begin
         r.status = STS_NO_BLOCK;
         return r;
      end
      while (found_o > need) begin
         tree[p][idx] = NODE_SPLIT;
         tree[p][2 * idx + 1] = NODE_FREE;
         tree[p][2 * idx] = NODE_FREE;
         idx = 2 * idx;
         found_o--;
      end
      tree[p][idx] = NODE_ALLOC;
      lvl = TOPO - found_o;
      addr = longint'(idx - (1 << lvl)) << found_o;
      ua = addr + hdr;
      if (user > 0) ua = (ua + user - 1) & ~longint'(user - 1);
      r.status = STS_OK;
      r.granted_address = addr[13:0];
      r.user_address = ua[13:0];
      r.granted_order = found_o[3:0];
      return r;
   endfunction

   function automatic rsp_type free_block(int p, int addr);
      rsp_type r;
      int      idx, o, base;
      bit      walking;
      r = '0;
      r.status = STS_NOT_ALLOC;
      if (p >= POOLS || addr >= (1 << TOPO)) return r;
      idx = 1;
      o = TOPO;
      walking = 1;
      // walk down split nodes toward the allocated block
      while (walking) begin
         if (tree[p][idx] == NODE_ALLOC) begin
            if ((addr & ((1 << o) - 1)) != 0) return r;
            walking = 0;
         end else if (tree[p][idx] == NODE_SPLIT && o > MINO) begin
            o--;
            idx = 2 * idx + ((addr >> o) & 1);
         end else begin
            return r;
         end
      end
      tree[p][idx] = NODE_FREE;
      // merge with buddy while it is free
      while (idx > 1 && tree[p][idx ^ 1] == NODE_FREE) begin
         tree[p][idx] = NODE_ABSENT;
         tree[p][idx ^ 1] = NODE_ABSENT;
         idx = idx >> 1;
         o++;
         tree[p][idx] = NODE_FREE;
      end
      base = (idx - (1 << (TOPO - o))) << o;
      r.status = STS_OK;
      r.granted_address = base[13:0];
      r.granted_order = o[3:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int p = 0; p < POOLS; p++) begin
            for (int n = 0; n < NODES; n++) tree[p][n] = NODE_ABSENT;
            tree[p][1] = NODE_FREE;
         end
         header_reg = HDR_RESET;
         expected_rsps.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_IDX_HEADER)
            header_reg = csr_pwdata[7:0];
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
               if (rsp_data.granted_address !== want.granted_address)
                  $error("granted_address expected %0d actual %0d",
                         want.granted_address, rsp_data.granted_address);
               if (rsp_data.user_address !== want.user_address)
                  $error("user_address expected %0d actual %0d",
                         want.user_address, rsp_data.user_address);
               if (rsp_data.granted_order !== want.granted_order)
                  $error("granted_order expected %0d actual %0d",
                         want.granted_order, rsp_data.granted_order);
               if (rsp_data !== want) fail_count <= fail_count + 1;
            end
         end
         if (start && !busy) begin
            if (req_data.command == CMD_ALLOC)
               expected_rsps.push_back(alloc_block(int'(req_data.pool),
                                                   int'(req_data.request_size)));
            else
               expected_rsps.push_back(free_block(int'(req_data.pool),
                                                  int'(req_data.block_address)));
         end
         pending <= expected_rsps.size();
      end
   end

endmodule

>>> verif/tb_buddy_block_allocator_unit.sv
module tb_buddy_block_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import bba_pkg::*;

   // generous bound: clearing pass plus worst-case scans for every beat
   localparam int CYCLE_LIMIT = 6000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;
   int                  fail_count;
   int                  pending;
   int                  cycles = 0;
   bit                  idling_on = 1'b1;
   int                  ok_allocs = 0;
   int                  ok_frees = 0;
   int                  failed_reqs = 0;
   int                  sent = 0;

   // commands in flight, and blocks currently held (pool in bits 16+, address below)
   req_type             in_flight [$];
   int                  held_blocks [$];

   always #5 clock = ~clock;

   buddy_block_allocator_unit dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   bba_checker u_check (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   // track which blocks are live so that frees can target real allocations
   always @(posedge clock) begin
      req_type cmd;
      if (!reset) begin
         if (start && !busy) in_flight.push_back(req_data);
         if (rsp_valid && in_flight.size() > 0) begin
            cmd = in_flight.pop_front();
            if (rsp_data.status != STS_OK) failed_reqs++;
            else if (cmd.command == CMD_ALLOC) begin
               ok_allocs++;
               held_blocks.push_back((int'(cmd.pool) << 16) | int'(rsp_data.granted_address));
            end else ok_frees++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // present one beat; start then stays high unless a random gap or the caller drops it
   task automatic send_beat(logic cmd, int pool, int size, int addr);
      start <= 1'b1;
      req_data.command <= cmd;
      req_data.pool <= pool[2:0];
      req_data.request_size <= size[13:0];
      req_data.block_address <= addr[13:0];
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sent++;
      // random gap between beats
      if (idling_on && $urandom_range(99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // drop start and wait until every expected result has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_header(logic [7:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(CSR_IDX_HEADER);
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // free a random held block and forget it
   task automatic free_held();
      int pick, entry;
      pick = $urandom_range(held_blocks.size() - 1);
      entry = held_blocks[pick];
      held_blocks.delete(pick);
      send_beat(CMD_FREE, entry >> 16, $urandom_range(16383), entry & 16'hffff);
   endtask

   task automatic random_phase(int count);
      int k, roll, size;
      for (k = 0; k < count; k++) begin
         // forty beats from a third of the way into each phase run without gaps
         idling_on = !(k >= count / 3 && k < count / 3 + 40);
         roll = $urandom_range(99);
         if (roll < 55 || held_blocks.size() == 0) begin
            // mostly small sizes, now and then anything up to the field limit
            case ($urandom_range(9))
               0:       size = $urandom_range(16383);
               1, 2:    size = $urandom_range(1024);
               default: size = $urandom_range(64);
            endcase
            send_beat(CMD_ALLOC, $urandom_range(7), size, $urandom_range(16383));
         end else if (roll < 90) begin
            free_held();
         end else begin
            // noise: free of an arbitrary address, often not a live block
            send_beat(CMD_FREE, $urandom_range(7), $urandom_range(16383),
                      $urandom_range(16383));
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both commands, the failure cases
      send_beat(CMD_ALLOC, 0, 0, 0);
      send_beat(CMD_ALLOC, 0, 1, 16383);
      send_beat(CMD_ALLOC, 0, 16383, 0);
      send_beat(CMD_ALLOC, 7, 8192, 0);
      send_beat(CMD_ALLOC, 7, 16, 0);
      send_beat(CMD_FREE, 7, 0, 0);
      send_beat(CMD_FREE, 7, 16383, 0);
      send_beat(CMD_ALLOC, 3, 100, 0);
      send_beat(CMD_FREE, 3, 0, 8);
      send_beat(CMD_FREE, 3, 0, 16383);
      send_beat(CMD_FREE, 0, 0, 0);
      send_beat(CMD_FREE, 0, 0, 0);
      send_beat(CMD_FREE, 5, 0, 0);
      send_beat(CMD_ALLOC, 0, 8, 0);
      send_beat(CMD_ALLOC, 0, 16, 0);
      send_beat(CMD_FREE, 0, 0, 64);
      send_beat(CMD_FREE, 0, 0, 128);
      send_beat(CMD_ALLOC, 2, 4096, 0);
      send_beat(CMD_ALLOC, 2, 4096, 0);
      send_beat(CMD_ALLOC, 2, 4096, 0);
      drain();
      // release whatever the directed part left allocated
      while (held_blocks.size() > 0) free_held();
      drain();

      random_phase(150);
      drain();
      write_header(8'd0);
      random_phase(130);
      drain();
      write_header(8'd255);
      random_phase(100);
      drain();
      write_header(8'd8);
      random_phase(90);
      drain();
      write_header(8'($urandom_range(255)));
      random_phase(80);
      drain();

      $display("beats sent %0d: %0d allocations and %0d frees granted, %0d refused",
               sent, ok_allocs, ok_frees, failed_reqs);
      $display("header settings 40, 0, 255, 8 and one random value, all pools");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> buddy_block_allocator_unit.f
sv/bba_pkg.sv
sv/buddy_block_allocator_unit.sv
verif/bba_checker.sv
verif/tb_buddy_block_allocator_unit.sv
